// ----- hw/rtl/ksa_pkg.sv -----
`default_nettype none

package ksa_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int TICKET_W = 32;
  localparam int MIN_W    = 27;
  localparam int CHARGE_W = 32;
  localparam int SLOT_W   = 4;
  localparam int RATE_W   = 8;
  localparam int MINC_W   = 16;
  localparam int CFG_W    = 16;
  localparam int COST_W   = MIN_W + RATE_W;

  localparam logic [RATE_W-1:0] RATE_RESET = 8'd2;
  localparam logic [MINC_W-1:0] MINC_RESET = 16'd10;

  // floor(x / 60) = (x * DIV60_MAGIC) >> DIV60_SHIFT for any 32-bit x
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  typedef enum logic [0:0] {
    CFG_RATE = 1'b0,
    CFG_MINC = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_EMPTY_KEY = 3'd3,
    ST_PRESENT   = 3'd4,
    ST_FULL      = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_ALLOC,
    S_DIFF,
    S_DIV,
    S_CEIL,
    S_MUL,
    S_REL
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    pop;
    logic    alloc;
    logic    diff;
    logic    div;
    logic    ceil;
    logic    mul;
    logic    release_slot;
    logic    emit;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic match;
    logic scan_end;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ksa_ctrl.sv -----
`default_nettype none

module ksa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    op,
  output logic               busy,
  output ksa_pkg::cmd_t      cmd,
  input  wire ksa_pkg::sts_t sts
);

  ksa_pkg::state_t state, state_next;
  ksa_pkg::op_t    op_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ksa_pkg::S_IDLE;
      op_reg <= ksa_pkg::OP_NONE;
    end else begin
      state <= state_next;
      if (state == ksa_pkg::S_IDLE && start) begin
        op_reg <= ksa_pkg::op_t'(op);
      end
    end
  end

  assign busy = (state != ksa_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ksa_pkg::S_IDLE: begin
        if (start && ksa_pkg::op_t'(op) != ksa_pkg::OP_NONE) begin
          state_next = ksa_pkg::S_SCAN;
        end
      end
      ksa_pkg::S_SCAN: begin
        if (op_reg == ksa_pkg::OP_ALLOC && sts.key_zero) begin
          state_next = ksa_pkg::S_IDLE;
        end else if (sts.match) begin
          state_next = (op_reg == ksa_pkg::OP_RELEASE) ? ksa_pkg::S_DIFF : ksa_pkg::S_IDLE;
        end else if (sts.scan_end) begin
          state_next = (op_reg == ksa_pkg::OP_ALLOC && !sts.full) ? ksa_pkg::S_POP
                                                                  : ksa_pkg::S_IDLE;
        end
      end
      ksa_pkg::S_POP:   state_next = ksa_pkg::S_ALLOC;
      ksa_pkg::S_ALLOC: state_next = ksa_pkg::S_IDLE;
      ksa_pkg::S_DIFF:  state_next = ksa_pkg::S_DIV;
      ksa_pkg::S_DIV:   state_next = ksa_pkg::S_CEIL;
      ksa_pkg::S_CEIL:  state_next = ksa_pkg::S_MUL;
      ksa_pkg::S_MUL:   state_next = ksa_pkg::S_REL;
      ksa_pkg::S_REL:   state_next = ksa_pkg::S_IDLE;
      default:          state_next = ksa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ksa_pkg::ST_ALLOCATED;
    case (state)
      ksa_pkg::S_IDLE: begin
        cmd.load = start;
      end
      ksa_pkg::S_SCAN: begin
        if (op_reg == ksa_pkg::OP_ALLOC && sts.key_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = ksa_pkg::ST_EMPTY_KEY;
        end else if (sts.match) begin
          case (op_reg)
            ksa_pkg::OP_ALLOC: begin
              cmd.emit   = 1'b1;
              cmd.status = ksa_pkg::ST_PRESENT;
            end
            ksa_pkg::OP_SEARCH: begin
              cmd.emit   = 1'b1;
              cmd.status = ksa_pkg::ST_FOUND;
            end
            default: begin
              cmd.emit = 1'b0;
            end
          endcase
        end else if (sts.scan_end) begin
          if (op_reg == ksa_pkg::OP_ALLOC) begin
            if (sts.full) begin
              cmd.emit   = 1'b1;
              cmd.status = ksa_pkg::ST_FULL;
            end
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = ksa_pkg::ST_NOT_FOUND;
          end
        end else begin
          cmd.rd = 1'b1;
        end
      end
      ksa_pkg::S_POP: begin
        cmd.pop = 1'b1;
      end
      ksa_pkg::S_ALLOC: begin
        cmd.alloc  = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = ksa_pkg::ST_ALLOCATED;
      end
      ksa_pkg::S_DIFF: cmd.diff = 1'b1;
      ksa_pkg::S_DIV:  cmd.div  = 1'b1;
      ksa_pkg::S_CEIL: cmd.ceil = 1'b1;
      ksa_pkg::S_MUL:  cmd.mul  = 1'b1;
      ksa_pkg::S_REL: begin
        cmd.release_slot = 1'b1;
        cmd.emit         = 1'b1;
        cmd.status       = ksa_pkg::ST_RELEASED;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ksa_dp.sv -----
`default_nettype none

module ksa_dp #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ksa_pkg::cmd_t                     cmd,
  output ksa_pkg::sts_t                          sts,
  input  wire logic [ksa_pkg::KEY_W-1:0]         entry_key,
  input  wire logic [ksa_pkg::TIME_W-1:0]        now_seconds,
  input  wire logic                              cfg_write,
  input  wire logic                              cfg_index,
  input  wire logic [ksa_pkg::CFG_W-1:0]         cfg_data,
  output logic                                   done,
  output logic [2:0]                             status,
  output logic [ksa_pkg::SLOT_W-1:0]             slot_number,
  output logic [ksa_pkg::TICKET_W-1:0]           ticket_number,
  output logic [ksa_pkg::MIN_W-1:0]              minutes_used,
  output logic [ksa_pkg::CHARGE_W-1:0]           charge,
  output logic [ksa_pkg::TIME_W-1:0]             entry_stamp
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  logic [ksa_pkg::RATE_W-1:0] rate;
  logic [ksa_pkg::MINC_W-1:0] min_charge;

  logic [ksa_pkg::KEY_W-1:0]    key_reg;
  logic [ksa_pkg::TIME_W-1:0]   now_reg;

  logic [ksa_pkg::KEY_W-1:0]    key_mem  [NUM_SLOTS];
  logic [ksa_pkg::TICKET_W-1:0] tick_mem [NUM_SLOTS];
  logic [ksa_pkg::TIME_W-1:0]   time_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]         busy_bits;

  logic [IW-1:0]                scan_addr;
  logic [ksa_pkg::KEY_W-1:0]    rd_key;
  logic [ksa_pkg::TICKET_W-1:0] rd_tick;
  logic [ksa_pkg::TIME_W-1:0]   rd_time;
  logic                         rd_busy;
  logic [IW-1:0]                rd_idx;
  logic                         rd_vld;

  logic [IW-1:0]                fifo_mem [NUM_SLOTS];
  logic [IW-1:0]                head;
  logic [IW-1:0]                tail;
  logic                         tail_wrap;
  logic [CW-1:0]                free_count;
  logic [IW-1:0]                fifo_q;
  logic                         fifo_written;
  logic [IW-1:0]                pop_idx;
  logic [ksa_pkg::TICKET_W-1:0] next_ticket;

  logic [ksa_pkg::TIME_W-1:0]   diff;
  logic [63:0]                  prod;
  logic [ksa_pkg::MIN_W-1:0]    quot;
  logic [ksa_pkg::TIME_W:0]     quot_x60;
  logic [ksa_pkg::MIN_W-1:0]    minutes;
  logic [ksa_pkg::COST_W-1:0]   cost;
  logic [ksa_pkg::CHARGE_W-1:0] cost_sat;
  logic [ksa_pkg::CHARGE_W-1:0] charge_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= ksa_pkg::RATE_RESET;
      min_charge <= ksa_pkg::MINC_RESET;
    end else if (cfg_write) begin
      case (ksa_pkg::cfg_idx_t'(cfg_index))
        ksa_pkg::CFG_RATE: rate       <= cfg_data[ksa_pkg::RATE_W-1:0];
        ksa_pkg::CFG_MINC: min_charge <= cfg_data[ksa_pkg::MINC_W-1:0];
        default:           rate       <= rate;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg <= entry_key;
      now_reg <= now_seconds;
    end
  end

  // key scan: one table entry read per cycle, compared on the next
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
    end else if (cmd.load) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
    end else if (cmd.rd) begin
      rd_vld <= 1'b1;
      if (scan_addr != LAST_IDX) begin
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key  <= key_mem[scan_addr];
      rd_tick <= tick_mem[scan_addr];
      rd_time <= time_mem[scan_addr];
      rd_busy <= busy_bits[scan_addr];
      rd_idx  <= scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      key_mem[pop_idx]  <= key_reg;
      tick_mem[pop_idx] <= next_ticket;
      time_mem[pop_idx] <= now_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_bits <= '0;
    end else if (cmd.alloc) begin
      busy_bits[pop_idx] <= 1'b1;
    end else if (cmd.release_slot) begin
      busy_bits[rd_idx] <= 1'b0;
    end
  end

  assign sts.key_zero = (key_reg == '0);
  assign sts.match    = rd_vld && rd_busy && (rd_key == key_reg);
  assign sts.scan_end = rd_vld && (rd_idx == LAST_IDX);
  assign sts.full     = (free_count == '0);

  // free list; a position not yet written since reset is read as its own index
  always_ff @(posedge clk) begin
    if (cmd.release_slot) begin
      fifo_mem[tail] <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      fifo_q       <= fifo_mem[head];
      fifo_written <= tail_wrap || (head < tail);
    end
  end

  assign pop_idx = fifo_written ? fifo_q : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      tail_wrap   <= 1'b0;
      free_count  <= CW'(NUM_SLOTS);
      next_ticket <= ksa_pkg::TICKET_W'(1);
    end else begin
      if (cmd.alloc) begin
        head        <= (head == LAST_IDX) ? '0 : head + 1'b1;
        free_count  <= free_count - 1'b1;
        next_ticket <= next_ticket + 1'b1;
      end
      if (cmd.release_slot) begin
        if (tail == LAST_IDX) begin
          tail      <= '0;
          tail_wrap <= 1'b1;
        end else begin
          tail <= tail + 1'b1;
        end
        free_count <= free_count + 1'b1;
      end
    end
  end

  // metering: stay, minutes rounded up, charge
  assign quot     = prod[ksa_pkg::DIV60_SHIFT +: ksa_pkg::MIN_W];
  assign quot_x60 = {quot, 6'b0} - {quot, 2'b0};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff <= now_reg - rd_time;
    end
    if (cmd.div) begin
      prod <= 64'(diff) * 64'(ksa_pkg::DIV60_MAGIC);
    end
    if (cmd.ceil) begin
      minutes <= quot + ksa_pkg::MIN_W'(quot_x60 != {1'b0, diff});
    end
    if (cmd.mul) begin
      cost <= ksa_pkg::COST_W'(minutes) * ksa_pkg::COST_W'(rate);
    end
  end

  assign cost_sat   = (|cost[ksa_pkg::COST_W-1:ksa_pkg::CHARGE_W]) ? '1
                                                                   : cost[ksa_pkg::CHARGE_W-1:0];
  assign charge_val = (cost_sat < ksa_pkg::CHARGE_W'(min_charge))
                      ? ksa_pkg::CHARGE_W'(min_charge) : cost_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= cmd.status;
      slot_number   <= '0;
      ticket_number <= '0;
      minutes_used  <= '0;
      charge        <= '0;
      entry_stamp   <= '0;
      case (cmd.status)
        ksa_pkg::ST_ALLOCATED: begin
          slot_number   <= ksa_pkg::SLOT_W'(32'(pop_idx) + 32'd1);
          ticket_number <= next_ticket;
          entry_stamp   <= now_reg;
        end
        ksa_pkg::ST_RELEASED: begin
          slot_number   <= ksa_pkg::SLOT_W'(32'(rd_idx) + 32'd1);
          ticket_number <= rd_tick;
          minutes_used  <= minutes;
          charge        <= charge_val;
          entry_stamp   <= rd_time;
        end
        ksa_pkg::ST_FOUND: begin
          slot_number   <= ksa_pkg::SLOT_W'(32'(rd_idx) + 32'd1);
          ticket_number <= rd_tick;
          entry_stamp   <= rd_time;
        end
        default: begin
          slot_number <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_slot_allocator_with_metering.sv -----
`default_nettype none

// Keyed slot allocator with metering. An item is taken when start is high and
// busy is low; each item except op 3 produces exactly one result, shown for a
// single cycle with done high, and the receiver cannot stall it, so it must
// capture the result in that cycle. The key lookup walks the slot table memory
// one entry per cycle. An allocate with a zero key ends without reading the
// table; otherwise the lookup walks the table until a hit on a slot or the
// last entry. A successful allocate then pops the free list, and a release
// works out the stay, divides it by 60, rounds up and multiplies by the rate
// for the charge. Op 3 is taken and gives nothing. A new item may be started
// in the cycle in which done is high. Registers are written through
// cfg_write / cfg_index / cfg_data; the user must write them only while busy
// is low, as the block itself does not enforce it.
module keyed_slot_allocator_with_metering #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  op,
  input  wire logic [ksa_pkg::KEY_W-1:0]   entry_key,
  input  wire logic [ksa_pkg::TIME_W-1:0]  now_seconds,
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [ksa_pkg::CFG_W-1:0]   cfg_data,
  output logic                             done,
  output logic [2:0]                       status,
  output logic [ksa_pkg::SLOT_W-1:0]       slot_number,
  output logic [ksa_pkg::TICKET_W-1:0]     ticket_number,
  output logic [ksa_pkg::MIN_W-1:0]        minutes_used,
  output logic [ksa_pkg::CHARGE_W-1:0]     charge,
  output logic [ksa_pkg::TIME_W-1:0]       entry_stamp
);

  ksa_pkg::cmd_t cmd;
  ksa_pkg::sts_t sts;

  ksa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  ksa_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .entry_key     (entry_key),
    .now_seconds   (now_seconds),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .slot_number   (slot_number),
    .ticket_number (ticket_number),
    .minutes_used  (minutes_used),
    .charge        (charge),
    .entry_stamp   (entry_stamp)
  );

endmodule

`default_nettype wire
